// ===== src/lgr_pkg.sv =====
// Shared types, constants and cell-update functions for the Life row engine.
// Depends on nothing; every other file imports it.
package lgr_pkg;

   // Row geometry fixed by the payload fields
   localparam int unsigned RowWidth  = 64;
   localparam int unsigned MaxSize   = 64;
   localparam int unsigned SizeWidth = 7;
   localparam int unsigned IdxWidth  = 6;

   // Neighbor counts that matter under B3/S23
   localparam logic [3:0] BirthCount = 4'd3;
   localparam logic [3:0] KeepCount  = 4'd2;

   // One queued job: the rows around one accepted item and how to emit them
   typedef struct packed {
      logic [RowWidth-1:0]  row_up;
      logic [RowWidth-1:0]  row_mid;
      logic [RowWidth-1:0]  row_cur;
      logic [SizeWidth-1:0] size_n;
      logic [IdxWidth-1:0]  index;
      logic                 has_upper;
      logic                 is_final;
   } lgr_job_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic head_valid;
   } lgr_queue_status_type;

   // Mask of the columns in use for an effective size of 1..64
   function automatic logic [RowWidth-1:0] size_mask(input logic [SizeWidth-1:0] n);
      logic [RowWidth-1:0] m;
      if (n >= SizeWidth'(MaxSize)) begin
         m = '1;
      end else begin
         m = (RowWidth'(1) << n) - RowWidth'(1);
      end
      return m;
   endfunction

   // Clamp the raw size register to 1..MaxSize
   function automatic logic [SizeWidth-1:0] eff_size(input logic [SizeWidth-1:0] raw);
      logic [SizeWidth-1:0] n;
      if (raw == '0) begin
         n = SizeWidth'(1);
      end else if (raw > SizeWidth'(MaxSize)) begin
         n = SizeWidth'(MaxSize);
      end else begin
         n = raw;
      end
      return n;
   endfunction

   // One generation of a row; columns outside the row read as dead
   function automatic logic [RowWidth-1:0] evolve_row(input logic [RowWidth-1:0] up,
                                                      input logic [RowWidth-1:0] mid,
                                                      input logic [RowWidth-1:0] down);
      logic [RowWidth+1:0] pu;
      logic [RowWidth+1:0] pm;
      logic [RowWidth+1:0] pd;
      logic [3:0]          cnt;
      logic [RowWidth-1:0] res;
      pu  = {1'b0, up, 1'b0};
      pm  = {1'b0, mid, 1'b0};
      pd  = {1'b0, down, 1'b0};
      res = '0;
      for (int k = 0; k < RowWidth; k++) begin
         cnt = 4'(pu[k]) + 4'(pu[k+1]) + 4'(pu[k+2])
             + 4'(pm[k]) + 4'(pm[k+2])
             + 4'(pd[k]) + 4'(pd[k+1]) + 4'(pd[k+2]);
         res[k] = (cnt == BirthCount) || ((cnt == KeepCount) && mid[k]);
      end
      return res;
   endfunction

endpackage

// ===== src/life_generation_row_engine.sv =====
// Top level of the B3/S23 Life row engine: front, job queue, back.
// Depends on lgr_pkg, lgr_front, lgr_queue and lgr_back.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid/req_ready, req_row_cells     | in
//   rsp     | rsp_valid/rsp_ready, next_row_cells,   | out
//           | row_index, last_row                    |
//   csr     | csr_write_enable, csr_write_data       | in
//
// One row is taken per cycle while the queue is not full; each result is loaded
// into a single result register once its job reaches the queue head.
// The final row of a board with more than one row gives two results and so
// loads the result register twice; that register sets the sustained rate.
// Reset clears the row history and the queue and sets the size to 64.
// A stalled rsp side fills the queue of QUEUE_DEPTH jobs, then drops req_ready.
module life_generation_row_engine import lgr_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [SizeWidth-1:0] csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RowWidth-1:0]  req_row_cells,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RowWidth-1:0]  rsp_next_row_cells,
   output logic [IdxWidth-1:0]  rsp_row_index,
   output logic                 rsp_last_row
);

   lgr_queue_status_type             queue_status;
   lgr_job_type                      push_job;
   lgr_job_type                      head_job;
   logic                             push_valid;
   logic                             pop;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;

   lgr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_row_cells    (req_row_cells),
      .queue_status     (queue_status),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   lgr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_job     (push_job),
      .pop          (pop),
      .head_job     (head_job),
      .queue_status (queue_status),
      .count        (queue_count)
   );

   lgr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .queue_status       (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_next_row_cells (rsp_next_row_cells),
      .rsp_row_index      (rsp_row_index),
      .rsp_last_row       (rsp_last_row)
   );

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && queue_status.full))
      else $error("job pushed into full queue");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_status.head_valid)
      else $error("job popped from empty queue");

   // A pop with no push lowers the fill count by one
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (pop && !push_valid) |=> (queue_count == $past(queue_count) - 1'b1))
      else $error("queue count out of step with pops");

endmodule

// ===== src/lgr_front.sv =====
// Front end: size register, row history, and job classification per row.
// Depends on lgr_pkg; feeds lgr_queue.
module lgr_front import lgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [SizeWidth-1:0] csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RowWidth-1:0]  req_row_cells,
   input  lgr_queue_status_type queue_status,
   output logic                 push_valid,
   output lgr_job_type          push_job
);

   logic [SizeWidth-1:0] board_size_ff, board_size_in;
   logic [RowWidth-1:0]  row_above_ff, row_above_in;
   logic [RowWidth-1:0]  row_middle_ff, row_middle_in;
   logic [SizeWidth-1:0] rows_received_ff, rows_received_in;

   logic [SizeWidth-1:0] size_n;
   logic [RowWidth-1:0]  mask;
   logic [RowWidth-1:0]  cur_m, up_m, mid_m;
   logic                 accept;
   logic                 is_final;
   logic                 has_upper;

   // Classify the incoming row against the current size
   always_comb begin
      size_n    = eff_size(board_size_ff);
      mask      = size_mask(size_n);
      cur_m     = req_row_cells & mask;
      up_m      = row_above_ff & mask;
      mid_m     = row_middle_ff & mask;
      is_final  = ({1'b0, rows_received_ff} + 8'd1) >= {1'b0, size_n};
      has_upper = rows_received_ff != '0;
      req_ready = !queue_status.full;
      accept    = req_valid && req_ready;
   end

   // Build the job; rows that give no result are not queued
   always_comb begin
      push_valid         = accept && (has_upper || is_final);
      push_job.row_up    = up_m;
      push_job.row_mid   = mid_m;
      push_job.row_cur   = cur_m;
      push_job.size_n    = size_n;
      push_job.index     = rows_received_ff[IdxWidth-1:0];
      push_job.has_upper = has_upper;
      push_job.is_final  = is_final;
   end

   // Advance the row history, or clear it after the final row
   always_comb begin
      board_size_in    = csr_write_enable ? csr_write_data : board_size_ff;
      row_above_in     = row_above_ff;
      row_middle_in    = row_middle_ff;
      rows_received_in = rows_received_ff;
      if (accept) begin
         if (is_final) begin
            row_above_in     = '0;
            row_middle_in    = '0;
            rows_received_in = '0;
         end else begin
            row_above_in     = mid_m;
            row_middle_in    = cur_m;
            rows_received_in = rows_received_ff + SizeWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff    <= SizeWidth'(MaxSize);
         row_above_ff     <= '0;
         row_middle_ff    <= '0;
         rows_received_ff <= '0;
      end else begin
         board_size_ff    <= board_size_in;
         row_above_ff     <= row_above_in;
         row_middle_ff    <= row_middle_in;
         rows_received_ff <= rows_received_in;
      end
   end

endmodule

// ===== src/lgr_queue.sv =====
// Short job queue between the front and the back.
// Depends on lgr_pkg for the job and status types.
module lgr_queue import lgr_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  lgr_job_type          push_job,
   input  logic                 pop,
   output lgr_job_type          head_job,
   output lgr_queue_status_type queue_status,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PtrWidth = $clog2(DEPTH);
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   lgr_job_type         slots_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job                = slots_ff[rd_ptr_ff];
   assign queue_status.full       = count_ff == CntWidth'(DEPTH);
   assign queue_status.head_valid = count_ff != '0;
   assign count                   = count_ff;

endmodule

// ===== src/lgr_back.sv =====
// Back end: evaluates the queued rows and drives the result register.
// Depends on lgr_pkg; drains lgr_queue.
module lgr_back import lgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  lgr_job_type          head_job,
   input  lgr_queue_status_type queue_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RowWidth-1:0]  rsp_next_row_cells,
   output logic [IdxWidth-1:0]  rsp_row_index,
   output logic                 rsp_last_row
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RowWidth-1:0] cells_ff, cells_in;
   logic [IdxWidth-1:0] index_ff, index_in;
   logic                last_ff, last_in;
   logic                phase_ff, phase_in;

   logic                load;
   logic                take;
   logic                emit_upper;
   logic                done;
   logic [RowWidth-1:0] row_a, row_b, row_c;

   // Pick which result of the head job goes out next
   always_comb begin
      emit_upper = head_job.has_upper && !phase_ff;
      if (emit_upper) begin
         row_a    = head_job.row_up;
         row_b    = head_job.row_mid;
         row_c    = head_job.row_cur;
         index_in = head_job.index - IdxWidth'(1);
         last_in  = 1'b0;
         done     = !head_job.is_final;
      end else begin
         row_a    = head_job.has_upper ? head_job.row_mid : '0;
         row_b    = head_job.row_cur;
         row_c    = '0;
         index_in = head_job.index;
         last_in  = 1'b1;
         done     = 1'b1;
      end
      cells_in = evolve_row(row_a, row_b, row_c) & size_mask(head_job.size_n);
   end

   // Load the result register when it is empty or being drained
   always_comb begin
      load         = !rsp_valid_ff || rsp_ready;
      take         = load && queue_status.head_valid;
      pop          = take && done;
      rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      phase_in     = take ? !done : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // Hold the payload until transfer
   always_ff @(posedge clock) begin
      if (take) begin
         cells_ff <= cells_in;
         index_ff <= index_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_row_cells = cells_ff;
   assign rsp_row_index      = index_ff;
   assign rsp_last_row       = last_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the B3/S23 Life row engine: streams boards of rows,
// predicts every next-generation row and checks each result transfer in order.
// Depends on lgr_pkg and life_generation_row_engine.
module tb_top;
   import lgr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 200_000;
   localparam int HoldCycles  = 300;
   localparam int SettleDelay = 6;
   localparam int EndDelay    = 20;

   // One next-generation row as the block returns it
   typedef struct packed {
      logic [RowWidth-1:0] cells;
      logic [IdxWidth-1:0] index;
      logic                last;
   } gen_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [SizeWidth-1:0] csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [RowWidth-1:0]  req_row_cells = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [RowWidth-1:0]  rsp_next_row_cells;
   logic [IdxWidth-1:0]  rsp_row_index;
   logic                 rsp_last_row;

   // Predicted board state, mirrors the block after reset
   logic [SizeWidth-1:0] cfg_size    = SizeWidth'(64);
   logic [RowWidth-1:0]  hist_above  = '0;
   logic [RowWidth-1:0]  hist_middle = '0;
   logic [SizeWidth-1:0] rows_taken  = '0;

   gen_row_type expected_rows[$];

   int unsigned mismatch_count = 0;
   int unsigned rows_sent      = 0;
   int unsigned results_seen   = 0;
   int unsigned boards_done    = 0;
   int unsigned size_writes    = 0;
   int unsigned input_stalls   = 0;
   int unsigned cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   int unsigned hold_seq       = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;

   life_generation_row_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_row_cells      (req_row_cells),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_next_row_cells (rsp_next_row_cells),
      .rsp_row_index      (rsp_row_index),
      .rsp_last_row       (rsp_last_row)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int clamp_size(input logic [SizeWidth-1:0] raw);
      if (raw == '0) return 1;
      if (raw > SizeWidth'(MaxSize)) return MaxSize;
      return int'(raw);
   endfunction

   function automatic logic [RowWidth-1:0] column_mask(input int n);
      if (n >= RowWidth) return '1;
      return (RowWidth'(1) << n) - RowWidth'(1);
   endfunction

   // Count the eight neighbors of each column; columns off the edge are dead
   function automatic logic [RowWidth-1:0] next_generation(input logic [RowWidth-1:0] up,
                                                           input logic [RowWidth-1:0] mid,
                                                           input logic [RowWidth-1:0] down,
                                                           input int n);
      logic [RowWidth-1:0] res;
      int                  live;
      res = '0;
      for (int c = 0; c < n; c++) begin
         live = 0;
         for (int dc = -1; dc <= 1; dc++) begin
            if (c + dc >= 0 && c + dc < n) begin
               live += up[c+dc] + down[c+dc];
               if (dc != 0) live += mid[c+dc];
            end
         end
         res[c] = (live == BirthCount) || ((live == KeepCount) && mid[c]);
      end
      return res;
   endfunction

   // Advance the board state by one accepted row and queue the rows it yields
   task automatic predict_rows(input logic [RowWidth-1:0] cells);
      int                  n;
      int                  r;
      logic [RowWidth-1:0] mask;
      logic [RowWidth-1:0] cur;
      logic [RowWidth-1:0] up;
      logic [RowWidth-1:0] mid;
      gen_row_type         item;
      n    = clamp_size(cfg_size);
      mask = column_mask(n);
      cur  = cells & mask;
      up   = hist_above & mask;
      mid  = hist_middle & mask;
      r    = int'(rows_taken);
      if (r >= 1) begin
         item.cells = next_generation(up, mid, cur, n) & mask;
         item.index = IdxWidth'(r - 1);
         item.last  = 1'b0;
         expected_rows.push_back(item);
      end
      if (r + 1 >= n) begin
         item.cells = next_generation((r >= 1) ? mid : '0, cur, '0, n) & mask;
         item.index = IdxWidth'(r);
         item.last  = 1'b1;
         expected_rows.push_back(item);
         hist_above  = '0;
         hist_middle = '0;
         rows_taken  = '0;
      end else begin
         hist_above  = mid;
         hist_middle = cur;
         rows_taken  = SizeWidth'(r + 1);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : result_check
      gen_row_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_rows.size() == 0) begin
            note_mismatch($sformatf("unexpected result for row %0d", rsp_row_index));
         end else begin
            want = expected_rows.pop_front();
            if (rsp_next_row_cells !== want.cells)
               note_mismatch($sformatf("row %0d cells %h, want %h",
                                       want.index, rsp_next_row_cells, want.cells));
            if (rsp_row_index !== want.index)
               note_mismatch($sformatf("row index %0d, want %0d", rsp_row_index, want.index));
            if (rsp_last_row !== want.last)
               note_mismatch($sformatf("row %0d last flag %b, want %b",
                                       want.index, rsp_last_row, want.last));
            if (want.last) boards_done++;
         end
      end
   end

   // Receiver: random stalls, or a long counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Count input back-pressure and guard against a hang
   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && !req_ready) input_stalls++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d rows still expected",
                  cycle_count, expected_rows.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one row, idling first at the current rate, and hold it until the transfer
   task automatic send_row(input logic [RowWidth-1:0] cells);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_row_cells <= cells;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_rows(cells);
      rows_sent++;
   endtask

   // Drop valid and wait until every predicted row has been returned
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rows.size() != 0);
   endtask

   // Write the size only once the block has gone quiet
   task automatic write_board_size(input logic [SizeWidth-1:0] value);
      wait_drained();
      repeat (SettleDelay) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_size = value;
      size_writes++;
   endtask

   function automatic logic [RowWidth-1:0] pick_row();
      logic [RowWidth-1:0] a;
      logic [RowWidth-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1, 2: return a;
         3, 4:    return a & b;
         5, 6:    return a | b;
         7:       return '1;
         8:       return '0;
         default: return RowWidth'(7) << $urandom_range(RowWidth - 3);
      endcase
   endfunction

   function automatic logic [SizeWidth-1:0] pick_size();
      int k;
      k = $urandom_range(99);
      if (k < 3) return '0;
      if (k < 8) return SizeWidth'($urandom_range(127, 65));
      if (k < 70) return SizeWidth'($urandom_range(8, 1));
      if (k < 90) return SizeWidth'($urandom_range(32, 9));
      return SizeWidth'($urandom_range(64, 33));
   endfunction

   // ---------------------------------------------------------------- tests

   // One-row boards, including a zero size that acts as one
   task automatic test_tiny_boards();
      write_board_size(SizeWidth'(1));
      send_row('1);
      send_row('0);
      write_board_size('0);
      send_row(RowWidth'(1));
   endtask

   // Blinker on a 3x3 board with junk above the used columns
   task automatic test_blinker_masking();
      write_board_size(SizeWidth'(3));
      send_row({{(RowWidth-3){1'b1}}, 3'b000});
      send_row({{(RowWidth-3){1'b1}}, 3'b111});
      send_row({{(RowWidth-3){1'b0}}, 3'b000});
   endtask

   // Oversize register acts as 64; then shrink so the next row closes the board
   task automatic test_oversize_then_shrink();
      write_board_size('1);
      send_row('1);
      send_row('1);
      write_board_size(SizeWidth'(2));
      send_row('1);
   endtask

   // Grow the board after its first row
   task automatic test_grow_mid_board();
      write_board_size(SizeWidth'(2));
      send_row(RowWidth'(6));
      write_board_size(SizeWidth'(5));
      repeat (4) send_row(RowWidth'(14));
   endtask

   // Shrink below the rows already taken; the next row becomes the last
   task automatic test_shrink_past_end();
      write_board_size(SizeWidth'(10));
      repeat (5) send_row(pick_row());
      write_board_size(SizeWidth'(3));
      send_row(pick_row());
      write_board_size(SizeWidth'(64));
   endtask

   // Hold the result side long enough for the queue to fill and stall input
   task automatic test_result_hold_off();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_board_size(SizeWidth'(12));
      hold_seq <= hold_seq + 1;
      repeat (36) send_row(pick_row());
      wait_drained();
   endtask

   // Random boards with occasional size changes part-way through
   task automatic test_random_boards(input int budget, input int idle_pct,
                                     input int stall_rate);
      int sent_here;
      sent_here     = 0;
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      while (sent_here < budget) begin
         write_board_size(pick_size());
         do begin
            if (rows_taken != 0 && $urandom_range(99) < 3) write_board_size(pick_size());
            send_row(pick_row());
            sent_here++;
         end while (rows_taken != 0);
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_tiny_boards();
      test_blinker_masking();
      test_oversize_then_shrink();
      test_grow_mid_board();
      test_shrink_past_end();
      test_result_hold_off();
      test_random_boards(350, 0, 0);
      test_random_boards(350, 55, 0);
      test_random_boards(350, 0, 55);
      test_random_boards(350, 24, 24);
      wait_drained();
      repeat (EndDelay) @(posedge clock);
      $display("covered %0d rows over %0d boards, %0d results checked, %0d size writes",
               rows_sent, boards_done, results_seen, size_writes);
      $display("input held back for %0d cycles by result-side stalls", input_stalls);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/lgr_pkg.sv
src/lgr_front.sv
src/lgr_queue.sv
src/lgr_back.sv
src/life_generation_row_engine.sv
tb/sv/tb_top.sv
